/* src/chs_pkg.sv */
// Shared types and constants for the convex hull block.
// No dependencies.
package chs_pkg;

  // Control bundle broadcast to every sorting cell.
  typedef struct packed {
    logic mul;  // form cross products of incoming and held points
    logic cmp;  // compare, keep the earlier point, hand the other on
    logic shl;  // shift held points one cell towards the head
  } cell_ctrl_t;

  // Sets at or below this size bypass the hull run.
  localparam int SMALL_SET = 3;

endpackage

/* src/chs_pt_if.sv */
// Valid/ready channel carrying one input point per beat.
// Depends on nothing.
interface chs_pt_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic                last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

/* src/chs_hull_if.sv */
// Valid/ready channel carrying one hull vertex per beat.
// Depends on nothing.
interface chs_hull_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] hull_x;
  logic signed [W-1:0] hull_y;
  logic                last_vertex;

  modport source (output valid, hull_x, hull_y, last_vertex, input ready);
  modport sink   (input valid, hull_x, hull_y, last_vertex, output ready);
endinterface

/* src/chs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module chs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/chs_cell.sv */
// One cell of the systolic angular sorter: holds one point, compares it with
// the point arriving from the left and hands the later one to the right.
// Depends on chs_pkg.
module chs_cell #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  chs_pkg::cell_ctrl_t ctrl,
  input  logic signed [W-1:0] anc_x,
  input  logic signed [W-1:0] anc_y,
  input  logic                lin_v,
  input  logic signed [W-1:0] lin_x,
  input  logic signed [W-1:0] lin_y,
  input  logic                rin_v,
  input  logic signed [W-1:0] rin_x,
  input  logic signed [W-1:0] rin_y,
  output logic                hold_v,
  output logic signed [W-1:0] hold_x,
  output logic signed [W-1:0] hold_y,
  output logic                pass_v,
  output logic signed [W-1:0] pass_x,
  output logic signed [W-1:0] pass_y
);

  logic                  hv, iv;
  logic signed [W-1:0]   hx, hy, ix, iy;
  logic signed [2*W+1:0] p1, p2;
  logic [W+1:0]          la, lb;
  logic                  same;

  logic signed [W:0] dax, day, dbx, dby;
  logic [W:0]        aax, aay, abx, aby;
  logic              after, take_in;

  assign dax = (W+1)'(ix) - (W+1)'(anc_x);
  assign day = (W+1)'(iy) - (W+1)'(anc_y);
  assign dbx = (W+1)'(hx) - (W+1)'(anc_x);
  assign dby = (W+1)'(hy) - (W+1)'(anc_y);
  assign aax = dax[W] ? (W+1)'(-dax) : (W+1)'(dax);
  assign aay = day[W] ? (W+1)'(-day) : (W+1)'(day);
  assign abx = dbx[W] ? (W+1)'(-dbx) : (W+1)'(dbx);
  assign aby = dby[W] ? (W+1)'(-dby) : (W+1)'(dby);

  // collinear points lie on one ray from the anchor, so L1 length orders them
  assign after   = !same && ((p1 == p2) ? (la > lb) : (p1 < p2));
  assign take_in = iv && (!hv || !after);

  assign pass_v = hv && iv;
  assign pass_x = after ? ix : hx;
  assign pass_y = after ? iy : hy;
  assign hold_v = hv;
  assign hold_x = hx;
  assign hold_y = hy;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      iv <= 1'b0;
    end else if (ctrl.cmp) begin
      hv <= hv || iv;
      iv <= lin_v;
    end else if (ctrl.shl) begin
      hv <= rin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      p1   <= (2*W+2)'(dax) * (2*W+2)'(dby);
      p2   <= (2*W+2)'(day) * (2*W+2)'(dbx);
      la   <= (W+2)'(aax) + (W+2)'(aay);
      lb   <= (W+2)'(abx) + (W+2)'(aby);
      same <= (ix == hx) && (iy == hy);
    end
    if (ctrl.cmp) begin
      ix <= lin_x;
      iy <= lin_y;
      if (take_in) begin
        hx <= ix;
        hy <= iy;
      end
    end else if (ctrl.shl) begin
      hx <= rin_x;
      hy <= rin_y;
    end
  end

endmodule

/* src/convex_hull_graham_scan.sv */
// Top level of the convex hull engine: point store, systolic angular sorter,
// stack scan and vertex output. Depends on chs_pkg, chs_pt_if, chs_hull_if,
// chs_ram and chs_cell.
//
// Usage: points enter on the points channel, one beat per cycle, while no run
// is in progress. The beat with last_point set closes the set; points beyond
// MAX_SET_POINTS are dropped. Hull vertices then leave on the hull channel
// counter-clockwise from the lowest point, last_vertex on the final one.
// Sets of three or fewer points come back as loaded.
// Sequence: the sort feeds every stored point and then flushes the cell row,
// each compare step following a multiply step; the scan pushes a point at once
// while fewer than three are stacked and skips repeats, else tests each point
// by cross product and pops the top while the turn is not strictly left.
// No new point is taken until the last vertex beat completes.
// A stalled receiver simply holds the vertex beat; nothing is lost.
// Reset (synchronous, rst high) empties the store and the cell row and
// returns the block to taking points.
module convex_hull_graham_scan #(
  parameter int MAX_SET_POINTS = 64,
  parameter int COORD_BITS     = 16
) (
  input logic         clk,
  input logic         rst,
  chs_pt_if.sink      points,
  chs_hull_if.source  hull
);

  localparam int W  = COORD_BITS;
  localparam int N  = MAX_SET_POINTS;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int SW = $clog2(2 * N + 1);

  typedef enum logic [8:0] {
    S_LOAD = 9'b000000001,
    S_FEED = 9'b000000010,
    S_PULL = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_DEC  = 9'b000010000,
    S_REF  = 9'b000100000,
    S_PUSH = 9'b001000000,
    S_ERD  = 9'b010000000,
    S_EOUT = 9'b100000000
  } state_t;

  state_t              state;
  logic                ecap;
  logic [CW-1:0]       cnt, tot, pulled, sc, ek, en;
  logic [SW-1:0]       step;
  logic                phase, feed_v, src_stack;
  logic signed [W-1:0] anc_x, anc_y;
  logic signed [W-1:0] s0x, s0y, s1x, s1y, px, py, prevx, prevy;
  logic signed [2*W+1:0] t1, t2;
  logic signed [W-1:0] ox, oy;
  logic                olast;

  chs_pkg::cell_ctrl_t ctrl;

  // point store
  logic              pr_we;
  logic [AW-1:0]     pr_raddr;
  logic [2*W-1:0]    pr_rdata;

  // hull stack
  logic              sr_we;
  logic [AW-1:0]     sr_raddr;
  logic [2*W-1:0]    sr_wdata, sr_rdata;
  logic [CW-1:0]     sc_m3;

  logic              in_acc, store_ok, lower;
  logic [CW-1:0]     n_new;
  logic signed [W-1:0] cur_x, cur_y;
  logic              dup, pull_push;
  logic signed [W:0] ex, ey, fx, fy;

  // cell row
  logic                c_hv [N];
  logic signed [W-1:0] c_hx [N];
  logic signed [W-1:0] c_hy [N];
  logic                c_pv [N];
  logic signed [W-1:0] c_px [N];
  logic signed [W-1:0] c_py [N];

  assign in_acc   = points.valid && points.ready;
  assign store_ok = cnt < CW'(N);
  assign n_new    = store_ok ? cnt + CW'(1) : cnt;
  assign lower    = (cnt == '0) || (points.point_y < anc_y) ||
                    ((points.point_y == anc_y) && (points.point_x < anc_x));

  assign points.ready    = (state == S_LOAD);
  assign hull.valid      = (state == S_EOUT);
  assign hull.hull_x     = ox;
  assign hull.hull_y     = oy;
  assign hull.last_vertex = olast;

  assign cur_x     = c_hx[0];
  assign cur_y     = c_hy[0];
  assign dup       = (pulled != '0) && (cur_x == prevx) && (cur_y == prevy);
  assign pull_push = (state == S_PULL) && (pulled != tot) && !dup &&
                     (sc < CW'(chs_pkg::SMALL_SET));

  assign ex = (W+1)'(s0x) - (W+1)'(s1x);
  assign ey = (W+1)'(s0y) - (W+1)'(s1y);
  assign fx = (W+1)'(px)  - (W+1)'(s1x);
  assign fy = (W+1)'(py)  - (W+1)'(s1y);

  assign sc_m3 = sc - CW'(chs_pkg::SMALL_SET);

  always_comb begin
    ctrl     = '0;
    ctrl.mul = (state == S_FEED) && !phase;
    ctrl.cmp = (state == S_FEED) && phase;
    ctrl.shl = (state == S_PULL) && (pulled != tot);
  end

  assign pr_we    = in_acc && store_ok;
  assign pr_raddr = (state == S_FEED) ? step[AW-1:0] : ek[AW-1:0];
  assign sr_we    = pull_push || ((state == S_DEC) && (t1 > t2)) ||
                    (state == S_PUSH);
  assign sr_wdata = (state == S_PULL) ? {cur_y, cur_x} : {py, px};
  assign sr_raddr = (state == S_DEC) ? sc_m3[AW-1:0] : ek[AW-1:0];

  chs_ram #(.WIDTH(2 * W), .DEPTH(N)) u_pts (
    .clk   (clk),
    .we    (pr_we),
    .waddr (cnt[AW-1:0]),
    .wdata ({points.point_y, points.point_x}),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  chs_ram #(.WIDTH(2 * W), .DEPTH(N)) u_stack (
    .clk   (clk),
    .we    (sr_we),
    .waddr (sc[AW-1:0]),
    .wdata (sr_wdata),
    .raddr (sr_raddr),
    .rdata (sr_rdata)
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic                lv, rv;
    logic signed [W-1:0] lx, ly, rx, ry;
    if (k == 0) begin : g_head
      assign lv = feed_v;
      assign lx = pr_rdata[W-1:0];
      assign ly = pr_rdata[2*W-1:W];
    end else begin : g_mid
      assign lv = c_pv[k-1];
      assign lx = c_px[k-1];
      assign ly = c_py[k-1];
    end
    if (k == N - 1) begin : g_tail
      assign rv = 1'b0;
      assign rx = '0;
      assign ry = '0;
    end else begin : g_body
      assign rv = c_hv[k+1];
      assign rx = c_hx[k+1];
      assign ry = c_hy[k+1];
    end
    chs_cell #(.W(W)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .anc_x  (anc_x),
      .anc_y  (anc_y),
      .lin_v  (lv),
      .lin_x  (lx),
      .lin_y  (ly),
      .rin_v  (rv),
      .rin_x  (rx),
      .rin_y  (ry),
      .hold_v (c_hv[k]),
      .hold_x (c_hx[k]),
      .hold_y (c_hy[k]),
      .pass_v (c_pv[k]),
      .pass_x (c_px[k]),
      .pass_y (c_py[k])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      ecap      <= 1'b0;
      cnt       <= '0;
      tot       <= '0;
      pulled    <= '0;
      sc        <= '0;
      ek        <= '0;
      en        <= '0;
      step      <= '0;
      phase     <= 1'b0;
      feed_v    <= 1'b0;
      src_stack <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (points.last_point) begin
              cnt    <= '0;
              tot    <= n_new;
              pulled <= '0;
              sc     <= '0;
              step   <= '0;
              phase  <= 1'b0;
              ek     <= '0;
              if (n_new <= CW'(chs_pkg::SMALL_SET)) begin
                en        <= n_new;
                src_stack <= 1'b0;
                state     <= S_ERD;
              end else begin
                state <= S_FEED;
              end
            end else begin
              cnt <= n_new;
            end
          end
        end
        S_FEED: begin
          phase <= !phase;
          if (!phase) begin
            feed_v <= SW'(step) < SW'(tot);
          end else begin
            step <= step + SW'(1);
            if (step == SW'(tot) + SW'(N - 1)) begin
              state <= S_PULL;
            end
          end
        end
        S_PULL: begin
          if (pulled == tot) begin
            en        <= sc;
            src_stack <= 1'b1;
            state     <= S_ERD;
          end else begin
            pulled <= pulled + CW'(1);
            if (!dup) begin
              if (sc < CW'(chs_pkg::SMALL_SET)) begin
                sc <= sc + CW'(1);
              end else begin
                state <= S_MUL;
              end
            end
          end
        end
        S_MUL: state <= S_DEC;
        S_DEC: begin
          if (t1 <= t2) begin
            sc    <= sc - CW'(1);
            state <= S_REF;
          end else begin
            sc    <= sc + CW'(1);
            state <= S_PULL;
          end
        end
        S_REF: begin
          state <= (sc >= CW'(chs_pkg::SMALL_SET)) ? S_MUL : S_PUSH;
        end
        S_PUSH: begin
          sc    <= sc + CW'(1);
          state <= S_PULL;
        end
        S_ERD: begin
          if (!ecap) begin
            ecap <= 1'b1;
          end else begin
            ecap  <= 1'b0;
            state <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (hull.ready) begin
            if (olast) begin
              state <= S_LOAD;
            end else begin
              ek    <= ek + CW'(1);
              state <= S_ERD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc && store_ok && lower) begin
      anc_x <= points.point_x;
      anc_y <= points.point_y;
    end
    if ((state == S_PULL) && (pulled != tot) && !dup) begin
      prevx <= cur_x;
      prevy <= cur_y;
      px    <= cur_x;
      py    <= cur_y;
    end
    if (pull_push || ((state == S_DEC) && (t1 > t2)) || (state == S_PUSH)) begin
      s1x <= s0x;
      s1y <= s0y;
      s0x <= (state == S_PULL) ? cur_x : px;
      s0y <= (state == S_PULL) ? cur_y : py;
    end
    if ((state == S_DEC) && (t1 <= t2)) begin
      s0x <= s1x;
      s0y <= s1y;
    end
    if (state == S_REF) begin
      s1x <= sr_rdata[W-1:0];
      s1y <= sr_rdata[2*W-1:W];
    end
    if (state == S_MUL) begin
      t1 <= (2*W+2)'(ex) * (2*W+2)'(fy);
      t2 <= (2*W+2)'(ey) * (2*W+2)'(fx);
    end
    if ((state == S_ERD) && ecap) begin
      ox    <= src_stack ? sr_rdata[W-1:0]   : pr_rdata[W-1:0];
      oy    <= src_stack ? sr_rdata[2*W-1:W] : pr_rdata[2*W-1:W];
      olast <= (ek == en - CW'(1));
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(points.ready && hull.valid))
    else $error("points taken while a vertex beat is offered");

  a_stack_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_REF) |-> (sc >= CW'(2)))
    else $error("hull stack popped below two entries");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (cnt <= CW'(N)) && (sc <= CW'(N)))
    else $error("point or stack count out of range");

  a_pull_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_PULL) |-> !c_pv[0])
    else $error("sorter still moving points during readout");
`endif

endmodule
